/* design/tlsd_pkg.sv */
// Shared constants for the TLS handshake deframer.
// Holds record types, result event codes, error codes and register defaults.
// No dependencies.
package tlsd_pkg;

   localparam int unsigned MAX_REC_LEN_W = 15;
   localparam int unsigned MAX_MSG_LEN_W = 25;
   localparam int unsigned MSG_LEN_W     = 24;

   localparam logic [MAX_REC_LEN_W-1:0] MAX_REC_LEN_RESET = 15'd18432;
   localparam logic [MAX_MSG_LEN_W-1:0] MAX_MSG_LEN_RESET = 25'd73728;

   localparam logic [7:0] REC_TYPE_CCS       = 8'd20;
   localparam logic [7:0] REC_TYPE_ALERT     = 8'd21;
   localparam logic [7:0] REC_TYPE_HANDSHAKE = 8'd22;

   localparam logic [2:0] REC_HDR_LEN_HIGH = 3'd3;
   localparam logic [2:0] REC_HDR_LEN_LOW  = 3'd4;
   localparam logic [2:0] REC_HDR_PAYLOAD  = 3'd5;
   localparam logic [2:0] MSG_HDR_DONE     = 3'd4;

   localparam logic [1:0] EVENT_MESSAGE = 2'd0;
   localparam logic [1:0] EVENT_CCS     = 2'd1;
   localparam logic [1:0] EVENT_ALERT   = 2'd2;
   localparam logic [1:0] EVENT_ERROR   = 2'd3;

   localparam logic [1:0] ERR_RECORD_LEN  = 2'd0;
   localparam logic [1:0] ERR_RECORD_TYPE = 2'd1;
   localparam logic [1:0] ERR_MESSAGE_LEN = 2'd2;

   localparam logic CSR_MAX_RECORD_LEN  = 1'b0;
   localparam logic CSR_MAX_MESSAGE_LEN = 1'b1;

endpackage

/* design/tls_handshake_deframer.sv */
// Any result of an accepted input byte is registered straight into the output register,
// which drains while the next byte is taken; one byte per cycle unless rsp_ready stalls.
// Reset: synchronous, active high; clears parse state, halt flag and output valid,
// and loads the length limits with their defaults. No clearing pass is needed.
// Depends on tlsd_pkg.
module tls_handshake_deframer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_stream_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_event_kind,
   output logic [7:0]  rsp_message_type,
   output logic [7:0]  rsp_data_byte,
   output logic        rsp_first_of_message,
   output logic        rsp_last_of_message,
   output logic [7:0]  rsp_alert_level,
   output logic [7:0]  rsp_alert_description,
   output logic [1:0]  rsp_error_code,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [24:0] csr_data
);

   logic [tlsd_pkg::MAX_REC_LEN_W-1:0] max_rec_len_ff;
   logic [tlsd_pkg::MAX_MSG_LEN_W-1:0] max_msg_len_ff;

   logic [2:0]  rec_hdr_cnt_ff, rec_hdr_cnt_in;
   logic [7:0]  rec_kind_ff, rec_kind_in;
   logic [7:0]  rec_len_high_ff, rec_len_high_in;
   logic [14:0] rec_rem_ff, rec_rem_in;
   logic [2:0]  msg_hdr_cnt_ff, msg_hdr_cnt_in;
   logic [7:0]  msg_kind_ff, msg_kind_in;
   logic [23:0] msg_rem_ff, msg_rem_in;
   logic [7:0]  alert_level_ff, alert_level_in;
   logic [7:0]  alert_desc_ff, alert_desc_in;
   logic [1:0]  alert_seen_ff, alert_seen_in;
   logic        halted_ff, halted_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [1:0]  rsp_kind_ff, res_kind;
   logic [7:0]  rsp_mtype_ff, res_mtype;
   logic [7:0]  rsp_data_ff, res_data;
   logic        rsp_first_ff, res_first;
   logic        rsp_last_ff, res_last;
   logic [7:0]  rsp_level_ff, res_level;
   logic [7:0]  rsp_desc_ff, res_desc;
   logic [1:0]  rsp_code_ff, res_code;
   logic        res_valid;

   logic        req_fire;
   logic [15:0] rec_len;
   logic [14:0] rec_rem_dec;
   logic        rec_end;
   logic [23:0] msg_rem_shift;
   logic [23:0] msg_rem_dec;
   logic [24:0] msg_total;
   logic [7:0]  b;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign b         = req_stream_byte;

   assign rec_len       = {rec_len_high_ff, b};
   assign rec_rem_dec   = (rec_rem_ff != 15'd0) ? rec_rem_ff - 15'd1 : rec_rem_ff;
   assign rec_end       = (rec_rem_dec == 15'd0);
   assign msg_rem_shift = {msg_rem_ff[15:0], b};
   assign msg_total     = {1'b0, msg_rem_shift} + 25'd4;
   assign msg_rem_dec   = (msg_rem_ff != 24'd0) ? msg_rem_ff - 24'd1 : msg_rem_ff;

   always_comb begin
      rec_hdr_cnt_in  = rec_hdr_cnt_ff;
      rec_kind_in     = rec_kind_ff;
      rec_len_high_in = rec_len_high_ff;
      rec_rem_in      = rec_rem_ff;
      msg_hdr_cnt_in  = msg_hdr_cnt_ff;
      msg_kind_in     = msg_kind_ff;
      msg_rem_in      = msg_rem_ff;
      alert_level_in  = alert_level_ff;
      alert_desc_in   = alert_desc_ff;
      alert_seen_in   = alert_seen_ff;
      halted_in       = halted_ff;
      res_valid       = 1'b0;
      res_kind        = tlsd_pkg::EVENT_MESSAGE;
      res_mtype       = 8'd0;
      res_data        = 8'd0;
      res_first       = 1'b0;
      res_last        = 1'b0;
      res_level       = 8'd0;
      res_desc        = 8'd0;
      res_code        = tlsd_pkg::ERR_RECORD_LEN;

      if (req_fire && !halted_ff) begin
         if (rec_hdr_cnt_ff < tlsd_pkg::REC_HDR_PAYLOAD) begin
            rec_hdr_cnt_in = rec_hdr_cnt_ff + 3'd1;
            if (rec_hdr_cnt_ff == 3'd0) begin
               rec_kind_in = b;
            end else if (rec_hdr_cnt_ff == tlsd_pkg::REC_HDR_LEN_HIGH) begin
               rec_len_high_in = b;
            end else if (rec_hdr_cnt_ff == tlsd_pkg::REC_HDR_LEN_LOW) begin
               rec_hdr_cnt_in = 3'd0;
               if (rec_len == 16'd0 || rec_len > {1'b0, max_rec_len_ff}) begin
                  halted_in = 1'b1;
                  res_valid = 1'b1;
                  res_kind  = tlsd_pkg::EVENT_ERROR;
                  res_code  = tlsd_pkg::ERR_RECORD_LEN;
               end else if (rec_kind_ff != tlsd_pkg::REC_TYPE_CCS &&
                            rec_kind_ff != tlsd_pkg::REC_TYPE_ALERT &&
                            rec_kind_ff != tlsd_pkg::REC_TYPE_HANDSHAKE) begin
                  halted_in = 1'b1;
                  res_valid = 1'b1;
                  res_kind  = tlsd_pkg::EVENT_ERROR;
                  res_code  = tlsd_pkg::ERR_RECORD_TYPE;
               end else begin
                  rec_rem_in     = rec_len[14:0];
                  rec_hdr_cnt_in = tlsd_pkg::REC_HDR_PAYLOAD;
                  if (rec_kind_ff == tlsd_pkg::REC_TYPE_ALERT) begin
                     alert_level_in = 8'd0;
                     alert_desc_in  = 8'd0;
                     alert_seen_in  = 2'd0;
                  end
               end
            end
         end else begin
            rec_rem_in = rec_rem_dec;
            if (rec_end) begin
               rec_hdr_cnt_in = 3'd0;
            end
            if (rec_kind_ff == tlsd_pkg::REC_TYPE_CCS) begin
               if (rec_end) begin
                  msg_hdr_cnt_in = 3'd0;
                  msg_kind_in    = 8'd0;
                  msg_rem_in     = 24'd0;
                  res_valid      = 1'b1;
                  res_kind       = tlsd_pkg::EVENT_CCS;
               end
            end else if (rec_kind_ff == tlsd_pkg::REC_TYPE_ALERT) begin
               if (alert_seen_ff == 2'd0) begin
                  alert_level_in = b;
                  alert_seen_in  = 2'd1;
               end else if (alert_seen_ff == 2'd1) begin
                  alert_desc_in = b;
                  alert_seen_in = 2'd2;
               end
               if (rec_end) begin
                  halted_in = 1'b1;
                  res_valid = 1'b1;
                  res_kind  = tlsd_pkg::EVENT_ALERT;
                  res_level = alert_level_in;
                  res_desc  = alert_desc_in;
               end
            end else if (rec_kind_ff == tlsd_pkg::REC_TYPE_HANDSHAKE) begin
               res_valid = 1'b1;
               res_kind  = tlsd_pkg::EVENT_MESSAGE;
               res_data  = b;
               res_mtype = msg_kind_ff;
               if (msg_hdr_cnt_ff == 3'd0) begin
                  msg_kind_in    = b;
                  msg_rem_in     = 24'd0;
                  msg_hdr_cnt_in = 3'd1;
                  res_mtype      = b;
                  res_first      = 1'b1;
               end else if (msg_hdr_cnt_ff < tlsd_pkg::MSG_HDR_DONE) begin
                  msg_rem_in     = msg_rem_shift;
                  msg_hdr_cnt_in = msg_hdr_cnt_ff + 3'd1;
                  if (msg_hdr_cnt_in == tlsd_pkg::MSG_HDR_DONE) begin
                     if (msg_total > max_msg_len_ff) begin
                        halted_in = 1'b1;
                        res_kind  = tlsd_pkg::EVENT_ERROR;
                        res_code  = tlsd_pkg::ERR_MESSAGE_LEN;
                        res_mtype = 8'd0;
                        res_data  = 8'd0;
                     end else if (msg_rem_shift == 24'd0) begin
                        res_last       = 1'b1;
                        msg_hdr_cnt_in = 3'd0;
                     end
                  end
               end else begin
                  msg_rem_in = msg_rem_dec;
                  if (msg_rem_dec == 24'd0) begin
                     res_last       = 1'b1;
                     msg_hdr_cnt_in = 3'd0;
                  end
               end
            end
         end
      end
   end

   always_comb begin
      if (req_fire) begin
         rsp_valid_in = res_valid;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_rec_len_ff  <= tlsd_pkg::MAX_REC_LEN_RESET;
         max_msg_len_ff  <= tlsd_pkg::MAX_MSG_LEN_RESET;
         rec_hdr_cnt_ff  <= 3'd0;
         rec_kind_ff     <= 8'd0;
         rec_len_high_ff <= 8'd0;
         rec_rem_ff      <= 15'd0;
         msg_hdr_cnt_ff  <= 3'd0;
         msg_kind_ff     <= 8'd0;
         msg_rem_ff      <= 24'd0;
         alert_level_ff  <= 8'd0;
         alert_desc_ff   <= 8'd0;
         alert_seen_ff   <= 2'd0;
         halted_ff       <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == tlsd_pkg::CSR_MAX_RECORD_LEN) begin
               max_rec_len_ff <= csr_data[14:0];
            end else begin
               max_msg_len_ff <= csr_data;
            end
         end
         rec_hdr_cnt_ff  <= rec_hdr_cnt_in;
         rec_kind_ff     <= rec_kind_in;
         rec_len_high_ff <= rec_len_high_in;
         rec_rem_ff      <= rec_rem_in;
         msg_hdr_cnt_ff  <= msg_hdr_cnt_in;
         msg_kind_ff     <= msg_kind_in;
         msg_rem_ff      <= msg_rem_in;
         alert_level_ff  <= alert_level_in;
         alert_desc_ff   <= alert_desc_in;
         alert_seen_ff   <= alert_seen_in;
         halted_ff       <= halted_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire && res_valid) begin
         rsp_kind_ff  <= res_kind;
         rsp_mtype_ff <= res_mtype;
         rsp_data_ff  <= res_data;
         rsp_first_ff <= res_first;
         rsp_last_ff  <= res_last;
         rsp_level_ff <= res_level;
         rsp_desc_ff  <= res_desc;
         rsp_code_ff  <= res_code;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_event_kind        = rsp_kind_ff;
   assign rsp_message_type      = rsp_mtype_ff;
   assign rsp_data_byte         = rsp_data_ff;
   assign rsp_first_of_message  = rsp_first_ff;
   assign rsp_last_of_message   = rsp_last_ff;
   assign rsp_alert_level       = rsp_level_ff;
   assign rsp_alert_description = rsp_desc_ff;
   assign rsp_error_code        = rsp_code_ff;

`ifndef SYNTHESIS
   a_halt_sticky: assert property (@(posedge clock) disable iff (reset)
      halted_ff |=> halted_ff)
      else $error("Halt flag cleared without reset.");

   a_stop_halts: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_kind_ff == tlsd_pkg::EVENT_ERROR ||
                        rsp_kind_ff == tlsd_pkg::EVENT_ALERT)) |-> halted_ff)
      else $error("Alert or error item reported without halting.");

   a_rec_cnt_range: assert property (@(posedge clock) disable iff (reset)
      rec_hdr_cnt_ff <= tlsd_pkg::REC_HDR_PAYLOAD)
      else $error("Record header count out of range.");

   a_msg_cnt_range: assert property (@(posedge clock) disable iff (reset)
      msg_hdr_cnt_ff <= tlsd_pkg::MSG_HDR_DONE)
      else $error("Message header count out of range.");
`endif

endmodule

/* tb/sv/tb.sv */
// Self-checking testbench for tls_handshake_deframer: it drives record streams, predicts
// every message byte and event, and compares each result on the output channel.
// Depends on tlsd_pkg and the design sources; it needs nothing else to run.
`timescale 1ns / 1ps

module tb;

   localparam int CYCLE_LIMIT = 400000;
   localparam int HOLD_CYCLES = 300;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] mtype;
      logic [7:0] data;
      logic       first_byte;
      logic       last_byte;
      logic [7:0] level;
      logic [7:0] desc;
      logic [1:0] code;
   } deframe_event_type;

   class deframe_scoreboard_type;
      logic [14:0]       max_record_len;
      logic [24:0]       max_message_len;
      logic [2:0]        rec_hdr_count;
      logic [7:0]        rec_type;
      logic [7:0]        rec_len_high;
      logic [14:0]       rec_left;
      logic [2:0]        msg_hdr_count;
      logic [7:0]        msg_type;
      logic [23:0]       msg_left;
      logic [7:0]        alert_level;
      logic [7:0]        alert_desc;
      logic [1:0]        alert_count;
      bit                stopped;
      deframe_event_type expected_events[$];
      int                mismatches;

      function new();
         max_record_len  = tlsd_pkg::MAX_REC_LEN_RESET;
         max_message_len = tlsd_pkg::MAX_MSG_LEN_RESET;
         rec_hdr_count   = '0;
         rec_type        = '0;
         rec_len_high    = '0;
         rec_left        = '0;
         msg_hdr_count   = '0;
         msg_type        = '0;
         msg_left        = '0;
         alert_level     = '0;
         alert_desc      = '0;
         alert_count     = '0;
         stopped         = 0;
         mismatches      = 0;
      endfunction

      function void write_reg(logic idx, logic [24:0] value);
         if (idx == tlsd_pkg::CSR_MAX_RECORD_LEN) begin
            max_record_len = value[14:0];
         end else begin
            max_message_len = value;
         end
      endfunction

      function void push_event(logic [1:0] kind, logic [7:0] mtype, logic [7:0] data,
                               logic fb, logic lb, logic [7:0] lvl, logic [7:0] dsc,
                               logic [1:0] code);
         deframe_event_type ev;
         ev = '{kind, mtype, data, fb, lb, lvl, dsc, code};
         expected_events.push_back(ev);
      endfunction

      function void halt_with_error(logic [1:0] code);
         stopped = 1;
         push_event(tlsd_pkg::EVENT_ERROR, '0, '0, 1'b0, 1'b0, '0, '0, code);
      endfunction

      function void note_stream_byte(logic [7:0] b);
         logic [15:0] rec_len;
         logic [24:0] msg_total;
         logic        at_end;
         logic        ends_msg;
         ends_msg = 1'b0;
         if (stopped) return;
         if (rec_hdr_count != tlsd_pkg::REC_HDR_PAYLOAD) begin
            if (rec_hdr_count == 3'd0) begin
               rec_type = b;
            end else if (rec_hdr_count == tlsd_pkg::REC_HDR_LEN_HIGH) begin
               rec_len_high = b;
            end else if (rec_hdr_count == tlsd_pkg::REC_HDR_LEN_LOW) begin
               rec_len = {rec_len_high, b};
               rec_hdr_count = 3'd0;
               if (rec_len == 16'd0 || rec_len > {1'b0, max_record_len}) begin
                  halt_with_error(tlsd_pkg::ERR_RECORD_LEN);
                  return;
               end
               if (rec_type != tlsd_pkg::REC_TYPE_CCS &&
                   rec_type != tlsd_pkg::REC_TYPE_ALERT &&
                   rec_type != tlsd_pkg::REC_TYPE_HANDSHAKE) begin
                  halt_with_error(tlsd_pkg::ERR_RECORD_TYPE);
                  return;
               end
               rec_left = rec_len[14:0];
               rec_hdr_count = tlsd_pkg::REC_HDR_PAYLOAD;
               if (rec_type == tlsd_pkg::REC_TYPE_ALERT) begin
                  alert_level = '0;
                  alert_desc  = '0;
                  alert_count = '0;
               end
               return;
            end
            rec_hdr_count++;
            return;
         end

         if (rec_left != 0) rec_left--;
         at_end = (rec_left == 0);
         if (at_end) rec_hdr_count = 3'd0;

         if (rec_type == tlsd_pkg::REC_TYPE_CCS) begin
            if (at_end) begin
               msg_hdr_count = '0;
               msg_type      = '0;
               msg_left      = '0;
               push_event(tlsd_pkg::EVENT_CCS, '0, '0, 1'b0, 1'b0, '0, '0, '0);
            end
            return;
         end
         if (rec_type == tlsd_pkg::REC_TYPE_ALERT) begin
            if (alert_count == 2'd0) begin
               alert_level = b;
               alert_count = 2'd1;
            end else if (alert_count == 2'd1) begin
               alert_desc  = b;
               alert_count = 2'd2;
            end
            if (at_end) begin
               stopped = 1;
               push_event(tlsd_pkg::EVENT_ALERT, '0, '0, 1'b0, 1'b0, alert_level,
                          alert_desc, '0);
            end
            return;
         end

         if (msg_hdr_count == 3'd0) begin
            msg_type      = b;
            msg_left      = '0;
            msg_hdr_count = 3'd1;
            push_event(tlsd_pkg::EVENT_MESSAGE, b, b, 1'b1, 1'b0, '0, '0, '0);
            return;
         end
         if (msg_hdr_count < tlsd_pkg::MSG_HDR_DONE) begin
            msg_left = {msg_left[15:0], b};
            msg_hdr_count++;
            if (msg_hdr_count == tlsd_pkg::MSG_HDR_DONE) begin
               msg_total = {1'b0, msg_left} + 25'd4;
               if (msg_total > max_message_len) begin
                  halt_with_error(tlsd_pkg::ERR_MESSAGE_LEN);
                  return;
               end
               if (msg_left == 0) begin
                  ends_msg = 1'b1;
                  msg_hdr_count = 3'd0;
               end
            end
         end else begin
            if (msg_left != 0) msg_left--;
            if (msg_left == 0) begin
               ends_msg = 1'b1;
               msg_hdr_count = 3'd0;
            end
         end
         push_event(tlsd_pkg::EVENT_MESSAGE, msg_type, b, 1'b0, ends_msg, '0, '0, '0);
      endfunction

      function string describe(deframe_event_type e);
         return $sformatf({"kind=%0d type=%02h data=%02h first=%0b last=%0b ",
                           "lvl=%02h desc=%02h code=%0d"},
                          e.kind, e.mtype, e.data, e.first_byte, e.last_byte, e.level,
                          e.desc, e.code);
      endfunction

      function void check_event(deframe_event_type got);
         deframe_event_type want;
         if (expected_events.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("Unexpected result: %s", describe(got));
            return;
         end
         want = expected_events.pop_front();
         if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("Result mismatch: expected %s", describe(want));
               $display("                 actual   %s", describe(got));
            end
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_stream_byte = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_event_kind;
   logic [7:0]  rsp_message_type;
   logic [7:0]  rsp_data_byte;
   logic        rsp_first_of_message;
   logic        rsp_last_of_message;
   logic [7:0]  rsp_alert_level;
   logic [7:0]  rsp_alert_description;
   logic [1:0]  rsp_error_code;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic        csr_index = tlsd_pkg::CSR_MAX_RECORD_LEN;
   logic [24:0] csr_data = '0;

   deframe_scoreboard_type sb = new();
   logic [7:0] pending_msg[$];
   int  sender_idle_pct = 0;
   int  rsp_stall_pct = 0;
   int  hold_requests = 0;
   int  holds_served = 0;
   int  hold_left = 0;
   int  bytes_sent = 0;
   int  cycle_count = 0;
   bit  offering = 0;

   tls_handshake_deframer dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_stream_byte       (req_stream_byte),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_event_kind        (rsp_event_kind),
      .rsp_message_type      (rsp_message_type),
      .rsp_data_byte         (rsp_data_byte),
      .rsp_first_of_message  (rsp_first_of_message),
      .rsp_last_of_message   (rsp_last_of_message),
      .rsp_alert_level       (rsp_alert_level),
      .rsp_alert_description (rsp_alert_description),
      .rsp_error_code        (rsp_error_code),
      .csr_valid             (csr_valid),
      .csr_ready             (csr_ready),
      .csr_index             (csr_index),
      .csr_data              (csr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (hold_requests != holds_served) begin
         holds_served <= hold_requests;
         hold_left    <= HOLD_CYCLES;
         rsp_ready    <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= (int'($urandom_range(0, 99)) >= rsp_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) sb.write_reg(csr_index, csr_data);
         if (req_valid && req_ready) sb.note_stream_byte(req_stream_byte);
         if (rsp_valid && rsp_ready) begin
            sb.check_event({rsp_event_kind, rsp_message_type, rsp_data_byte,
                            rsp_first_of_message, rsp_last_of_message, rsp_alert_level,
                            rsp_alert_description, rsp_error_code});
         end
      end
   end

   task automatic send_byte(input logic [7:0] b);
      int gap;
      gap = 0;
      req_valid       <= 1'b1;
      req_stream_byte <= b;
      offering = 1;
      do @(posedge clock); while (!req_ready);
      bytes_sent++;
      while (gap < 60 && int'($urandom_range(0, 99)) < sender_idle_pct) gap++;
      if (gap != 0) begin
         req_valid <= 1'b0;
         offering = 0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_idle();
      if (offering) begin
         req_valid <= 1'b0;
         offering = 0;
      end
      @(posedge clock);
      while (sb.expected_events.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_limits(input logic [24:0] rec_word, input logic [24:0] msg_word);
      csr_valid <= 1'b1;
      csr_index <= tlsd_pkg::CSR_MAX_RECORD_LEN;
      csr_data  <= rec_word;
      do @(posedge clock); while (!csr_ready);
      csr_index <= tlsd_pkg::CSR_MAX_MESSAGE_LEN;
      csr_data  <= msg_word;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   task automatic send_header(input logic [7:0] kind, input logic [15:0] len);
      send_byte(kind);
      send_byte(8'($urandom));
      send_byte(8'($urandom));
      send_byte(len[15:8]);
      send_byte(len[7:0]);
   endtask

   function automatic int record_size(int limit);
      int cap;
      cap = ($urandom_range(0, 7) == 0) ? 200 : 40;
      if (cap > int'(sb.max_record_len)) cap = int'(sb.max_record_len);
      if (cap > limit) cap = limit;
      return int'($urandom_range(1, cap));
   endfunction

   function automatic void queue_message(int declared, int sent);
      logic [23:0] len;
      len = 24'(declared);
      pending_msg.push_back(8'($urandom));
      pending_msg.push_back(len[23:16]);
      pending_msg.push_back(len[15:8]);
      pending_msg.push_back(len[7:0]);
      repeat (sent) pending_msg.push_back(8'($urandom));
   endfunction

   task automatic send_handshake_record(input int n);
      int max_body;
      int cap;
      int body;
      while (pending_msg.size() < n) begin
         max_body = int'(sb.max_message_len) - 4;
         cap = ($urandom_range(0, 7) == 0) ? 150 : 20;
         if (cap > max_body) cap = max_body;
         body = int'($urandom_range(0, cap));
         queue_message(body, body);
      end
      send_header(tlsd_pkg::REC_TYPE_HANDSHAKE, 16'(n));
      repeat (n) send_byte(pending_msg.pop_front());
   endtask

   task automatic send_ccs();
      int n;
      n = (sb.max_record_len < 3) ? int'(sb.max_record_len) : 3;
      n = int'($urandom_range(1, n));
      send_header(tlsd_pkg::REC_TYPE_CCS, 16'(n));
      repeat (n) send_byte(8'($urandom));
      pending_msg.delete();
   endtask

   // A message that declares a long body is cut short by a change cipher spec record.
   task automatic send_truncated_message();
      if (pending_msg.size() != 0) send_ccs();
      queue_message(int'($urandom_range(21, int'(sb.max_message_len) - 4)),
                    int'($urandom_range(0, 20)));
      while (pending_msg.size() != 0) send_handshake_record(record_size(pending_msg.size()));
      send_ccs();
   endtask

   initial begin
      int sender_modes[4];
      int receiver_modes[4];
      logic [24:0] rec_word;
      logic [24:0] msg_word;
      logic [7:0] bad_type;
      logic [23:0] long_len;
      int target;
      int pick;
      int n;

      sender_modes   = '{0, 81, 0, 19};
      receiver_modes = '{0, 0, 81, 19};
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Empty message, then a partial message dropped by a change cipher spec record,
      // then a complete one-byte message.
      send_header(tlsd_pkg::REC_TYPE_HANDSHAKE, 16'd6);
      send_byte(8'hFF);
      send_byte(8'h00);
      send_byte(8'h00);
      send_byte(8'h00);
      send_byte(8'h00);
      send_byte(8'h00);
      send_header(tlsd_pkg::REC_TYPE_CCS, 16'd1);
      send_byte(8'hFF);
      send_header(tlsd_pkg::REC_TYPE_HANDSHAKE, 16'd5);
      send_byte(8'h01);
      send_byte(8'h00);
      send_byte(8'h00);
      send_byte(8'h01);
      send_byte(8'hFF);

      for (int phase = 0; phase < 6; phase++) begin
         wait_idle();
         case (phase)
            0: begin rec_word = 25'd1;      msg_word = 25'd4;        end
            1: begin rec_word = 25'd32767;  msg_word = 25'd16777219; end
            2: begin rec_word = 25'h1FF801E; msg_word = 25'd40;      end
            3: begin
               rec_word = 25'($urandom_range(2, 50));
               msg_word = 25'($urandom_range(5, 120));
            end
            4: begin rec_word = 25'd3;      msg_word = 25'd16;       end
            default: begin
               rec_word = 25'($urandom_range(8, 300));
               msg_word = 25'($urandom_range(25, 2000));
            end
         endcase
         write_limits(rec_word, msg_word);
         sender_idle_pct = sender_modes[phase % 4];
         rsp_stall_pct  <= receiver_modes[phase % 4];

         if (phase == 1) begin
            sender_idle_pct = 0;
            hold_requests <= hold_requests + 1;
            repeat (3) send_handshake_record(30);
            wait_idle();
            sender_idle_pct = sender_modes[phase % 4];
         end

         target = bytes_sent + 260;
         while (bytes_sent < target) begin
            pick = int'($urandom_range(0, 99));
            if (pick < 8) begin
               send_ccs();
            end else if (pick < 14 && sb.max_message_len >= 25) begin
               send_truncated_message();
            end else begin
               send_handshake_record(record_size(1 << 30));
            end
         end
         if (pending_msg.size() != 0) send_ccs();
      end

      // Closing record halts the block: an alert or one of the errors.
      wait_idle();
      write_limits(25'd64, 25'd60);
      sender_idle_pct = 19;
      rsp_stall_pct  <= 19;
      case ($urandom_range(0, 5))
         0: begin
            send_header(tlsd_pkg::REC_TYPE_ALERT, 16'd1);
            send_byte(8'($urandom));
         end
         1: begin
            send_header(tlsd_pkg::REC_TYPE_ALERT, 16'd2);
            send_byte(8'($urandom));
            send_byte(8'($urandom));
         end
         2: begin
            n = int'($urandom_range(3, 8));
            send_header(tlsd_pkg::REC_TYPE_ALERT, 16'(n));
            repeat (n) send_byte(8'($urandom));
         end
         3: begin
            case ($urandom_range(0, 2))
               0:       send_header(8'($urandom), 16'd0);
               1:       send_header(8'($urandom), 16'hFFFF);
               default: send_header(8'($urandom), 16'($urandom_range(65, 65535)));
            endcase
         end
         4: begin
            do bad_type = 8'($urandom);
            while (bad_type == tlsd_pkg::REC_TYPE_CCS ||
                   bad_type == tlsd_pkg::REC_TYPE_ALERT ||
                   bad_type == tlsd_pkg::REC_TYPE_HANDSHAKE);
            send_header(bad_type, 16'($urandom_range(1, 64)));
         end
         default: begin
            long_len = 24'($urandom_range(57, 24'hFFFFFF));
            send_header(tlsd_pkg::REC_TYPE_HANDSHAKE, 16'd4);
            send_byte(8'($urandom));
            send_byte(long_len[23:16]);
            send_byte(long_len[15:8]);
            send_byte(long_len[7:0]);
         end
      endcase
      repeat (20) send_byte(8'($urandom));

      wait_idle();
      repeat (8) @(posedge clock);
      if (sb.mismatches == 0 && sb.expected_events.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

/* filelist.f */
design/tlsd_pkg.sv
design/tls_handshake_deframer.sv
tb/sv/tb.sv
